### rtl/core/identifier_case_converter_unit_defines.svh
// Assertion macros shared by the identifier case converter RTL.
// Included by the modules that carry concurrent assertions; needs nothing else.
`ifndef IDENTIFIER_CASE_CONVERTER_UNIT_DEFINES_SVH
`define IDENTIFIER_CASE_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define ICC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define ICC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// condition that must never be seen
`define ICC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

### rtl/core/icc_pkg.sv
// Package for the identifier case converter: payload and job types, mode codes,
// character class helpers and the per-byte conversion step. No dependencies.
`timescale 1ns / 1ps

package icc_pkg;

   localparam logic [2:0] MODE_UPPER = 3'd0;
   localparam logic [2:0] MODE_LOWER = 3'd1;
   localparam logic [2:0] MODE_TITLE = 3'd2;
   localparam logic [2:0] MODE_SNAKE = 3'd3;
   localparam logic [2:0] MODE_CAMEL = 3'd4;

   localparam logic [7:0] UNDERSCORE = 8'h5F;
   localparam logic [7:0] CASE_GAP   = 8'd32;
   localparam int         JOB_BYTES  = 4;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last_in;
   } icc_req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       byte_valid;
      logic       run_last;
      logic       stream_end;
   } icc_rsp_type;

   // word trackers carried from byte to byte
   typedef struct packed {
      logic [7:0] prev_char;
      logic       word_open;
      logic       any_word_done;
      logic       title_new;
   } icc_track_type;

   typedef struct packed {
      icc_track_type track;
      logic [1:0]    nb;
      logic [7:0]    b0;
      logic [7:0]    b1;
   } icc_step_type;

   // everything one request produces, handed from front to back
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      marker;
      logic                      stream_end;
   } icc_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } icc_qstat_type;

   localparam icc_track_type TRACK_RESET = '{
      prev_char: 8'd0, word_open: 1'b0, any_word_done: 1'b0, title_new: 1'b1};

   function automatic logic is_up(logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic is_lo(logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

   function automatic logic is_al(logic [7:0] c);
      return is_up(c) || is_lo(c);
   endfunction

   function automatic logic is_dg(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_an(logic [7:0] c);
      return is_al(c) || is_dg(c);
   endfunction

   function automatic logic [7:0] to_up(logic [7:0] c);
      return is_lo(c) ? c - CASE_GAP : c;
   endfunction

   function automatic logic [7:0] to_lo(logic [7:0] c);
      return is_up(c) ? c + CASE_GAP : c;
   endfunction

   // one byte through the trackers and the selected mode: zero to two bytes out
   function automatic icc_step_type icc_process(icc_track_type st, logic [2:0] mode,
                                                logic [7:0] ch, logic nxv,
                                                logic [7:0] nx);
      icc_step_type r;
      logic         starts;
      logic         prior;
      logic         alnum;
      logic [7:0]   p;
      r        = '0;
      r.track  = st;
      starts   = 1'b0;
      prior    = st.any_word_done;
      alnum    = is_an(ch);
      p        = st.prev_char;
      r.track.title_new = !is_al(ch);
      if (alnum) begin
         if (st.word_open) begin
            starts = (is_lo(p) && is_up(ch)) || (is_al(p) && is_dg(ch)) ||
                     (is_dg(p) && is_al(ch)) ||
                     (is_up(p) && is_up(ch) && nxv && is_lo(nx));
         end else begin
            starts = 1'b1;
         end
         r.track.word_open = 1'b1;
         r.track.prev_char = ch;
         if (starts) begin
            r.track.any_word_done = 1'b1;
         end
      end else begin
         r.track.word_open = 1'b0;
         r.track.prev_char = 8'd0;
      end
      case (mode)
         MODE_UPPER: begin
            r.nb = 2'd1;
            r.b0 = to_up(ch);
         end
         MODE_LOWER: begin
            r.nb = 2'd1;
            r.b0 = to_lo(ch);
         end
         MODE_TITLE: begin
            r.nb = 2'd1;
            r.b0 = is_al(ch) ? (st.title_new ? to_up(ch) : to_lo(ch)) : ch;
         end
         MODE_SNAKE: begin
            if (alnum) begin
               if (starts && prior) begin
                  r.nb = 2'd2;
                  r.b0 = UNDERSCORE;
                  r.b1 = to_lo(ch);
               end else begin
                  r.nb = 2'd1;
                  r.b0 = to_lo(ch);
               end
            end
         end
         MODE_CAMEL: begin
            if (alnum) begin
               r.nb = 2'd1;
               r.b0 = (starts && prior) ? to_up(ch) : to_lo(ch);
            end
         end
         default: begin
            r.nb = 2'd1;
            r.b0 = ch;
         end
      endcase
      return r;
   endfunction

endpackage

### rtl/core/icc_front.sv
// Front end: holds the mode register and the lookahead byte, converts each
// request into a job of up to four bytes. Depends on icc_pkg.
`timescale 1ns / 1ps

module icc_front
   import icc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  icc_req_type   req_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_data,
   input  icc_qstat_type q_stat,
   output logic          q_push,
   output icc_job_type   q_job
);

   logic [2:0]    mode_ff, mode_in;
   logic [7:0]    held_char_ff, held_char_in;
   logic          held_valid_ff, held_valid_in;
   icc_track_type trk_ff, trk_in;

   icc_step_type  s1, s2;
   icc_track_type trk_mid;
   logic [1:0]    n1, n2;
   logic [2:0]    total;
   logic          accept;

   assign csr_ready = 1'b1;
   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      // held byte first, with the incoming byte as its lookahead
      s1      = icc_process(trk_ff, mode_ff, held_char_ff, 1'b1, req_data.char_in);
      n1      = held_valid_ff ? s1.nb : 2'd0;
      trk_mid = held_valid_ff ? s1.track : trk_ff;
      s2      = icc_process(trk_mid, mode_ff, req_data.char_in, 1'b0, 8'd0);
      n2      = req_data.last_in ? s2.nb : 2'd0;
      total   = {1'b0, n1} + {1'b0, n2};

      q_job = '0;
      if (n1 != 2'd0) begin
         q_job.bytes[0] = s1.b0;
      end
      if (n1 == 2'd2) begin
         q_job.bytes[1] = s1.b1;
      end
      if (n2 != 2'd0) begin
         q_job.bytes[n1] = s2.b0;
      end
      if (n2 == 2'd2) begin
         q_job.bytes[n1 + 2'd1] = s2.b1;
      end
      q_job.stream_end = req_data.last_in;
      if (req_data.last_in && total == 3'd0) begin
         q_job.count  = 3'd1;
         q_job.marker = 1'b1;
      end else begin
         q_job.count = total;
      end
      q_push = accept && (q_job.count != 3'd0);

      mode_in       = (csr_valid && csr_ready) ? csr_data : mode_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      trk_in        = trk_ff;
      if (accept) begin
         if (req_data.last_in) begin
            held_char_in  = 8'd0;
            held_valid_in = 1'b0;
            trk_in        = TRACK_RESET;
         end else begin
            held_char_in  = req_data.char_in;
            held_valid_in = 1'b1;
            trk_in        = trk_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_UPPER;
         held_char_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         trk_ff        <= TRACK_RESET;
      end else begin
         mode_ff       <= mode_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         trk_ff        <= trk_in;
      end
   end

endmodule

### rtl/core/icc_queue.sv
// Two-entry job queue between front and back end.
// Depends on icc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "identifier_case_converter_unit_defines.svh"

module icc_queue
   import icc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  icc_job_type   push_job,
   input  logic          pop,
   output icc_job_type   pop_job,
   output icc_qstat_type stat
);

   icc_job_type slot0_ff;
   icc_job_type slot1_ff;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign stat.full  = cnt_ff == 2'd2;
   assign stat.empty = cnt_ff == 2'd0;
   assign pop_job    = rd_ptr_ff ? slot1_ff : slot0_ff;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !wr_ptr_ff) begin
         slot0_ff <= push_job;
      end
      if (push && wr_ptr_ff) begin
         slot1_ff <= push_job;
      end
   end

   `ICC_ASSERT_NEVER(a_no_push_full, clock, reset, push && stat.full, "push into full queue")
   `ICC_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && stat.empty, "pop from empty queue")
   `ICC_ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff == 2'd3, "queue count out of range")

endmodule

### rtl/core/icc_back.sv
// Back end: walks a job byte by byte into the registered response port.
// Depends on icc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "identifier_case_converter_unit_defines.svh"

module icc_back
   import icc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  icc_qstat_type q_stat,
   input  icc_job_type   q_job,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output icc_rsp_type   rsp_data
);

   icc_job_type job_ff, job_in;
   logic        job_valid_ff, job_valid_in;
   logic [1:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   icc_rsp_type rsp_ff, rsp_in;

   logic out_free;
   logic last_idx;
   logic advance;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      last_idx = {1'b0, idx_ff} == (job_ff.count - 3'd1);
      advance  = out_free && job_valid_ff;
      // refill as the current job's final byte goes out
      q_pop    = !q_stat.empty && (!job_valid_ff || (advance && last_idx));

      job_in       = q_pop ? q_job : job_ff;
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         job_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (advance) begin
         job_valid_in = !last_idx;
         idx_in       = idx_ff + 2'd1;
      end

      rsp_valid_in = out_free ? job_valid_ff : rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_in.byte_out   = job_ff.bytes[idx_ff];
         rsp_in.byte_valid = !job_ff.marker;
         rsp_in.run_last   = last_idx;
         rsp_in.stream_end = last_idx && job_ff.stream_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   `ICC_ASSERT_IMPLY(a_job_nonempty, clock, reset, job_valid_ff, job_ff.count != 3'd0,
                     "empty job held")
   `ICC_ASSERT_IMPLY(a_idx_range, clock, reset, job_valid_ff,
                     ({1'b0, idx_ff} < job_ff.count), "job index past count")
   `ICC_ASSERT_IMPLY(a_end_is_run_last, clock, reset, rsp_valid_ff && rsp_ff.stream_end,
                     rsp_ff.run_last, "stream end without run last")
   `ICC_ASSERT_IMPLY(a_marker_ends, clock, reset, rsp_valid_ff && !rsp_ff.byte_valid,
                     rsp_ff.stream_end && rsp_ff.run_last, "bare marker not at stream end")

endmodule

### rtl/core/identifier_case_converter_unit.sv
// Identifier case converter: text in one byte per request, converted bytes out
// as upper, lower, title, snake or camel case (csr_data selects; codes 5 to 7
// pass bytes through). Every byte is held back until the next request arrives,
// which serves as its lookahead, so the first byte of a text yields nothing
// and the last request releases both the held and the final byte; an end of
// text with no output byte gives one bare marker (byte_valid low). A request
// is taken in every cycle while the two-entry job queue has room; responses
// leave at one per cycle while jobs wait and rsp_ready is high; a request
// makes none to four (at most two for most text), and its job passes through
// the queue slot and the job register into the response register. Write the mode
// only while idle. Depends on icc_pkg, icc_front, icc_queue and icc_back.
`timescale 1ns / 1ps

module identifier_case_converter_unit
   import icc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  icc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output icc_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data
);

   icc_qstat_type q_stat;
   icc_job_type   push_job, pop_job;
   logic          q_push, q_pop;

   icc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   icc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .stat     (q_stat)
   );

   icc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_job     (pop_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### bench/tb_identifier_case_converter_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for identifier_case_converter_unit: drives text requests
// under random idling and back-pressure and predicts every converted byte.
// Depends on icc_pkg and the identifier_case_converter_unit RTL.

module tb_identifier_case_converter_unit;
   import icc_pkg::*;

   localparam int         SETTLE_CYCLES   = 10;
   localparam int         HOLD_OFF_CYCLES = 300;
   localparam logic [2:0] MODE_PASS_TOP   = 3'd7;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   icc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   icc_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_data  = '0;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_off_left  = 0;
   int mismatch_count = 0;

   icc_rsp_type pending_rsp_q[$];
   logic [7:0]  step_bytes_q[$];
   icc_rsp_type want_rsp;

   // converter state as the bench sees it
   logic [2:0] cur_mode;
   logic [7:0] pend_char;
   logic       pend_valid;
   logic [7:0] word_prev;
   logic       in_word;
   logic       word_seen;
   logic       cap_next;

   identifier_case_converter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic upper_ch(logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic lower_ch(logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

   function automatic logic digit_ch(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic alpha_ch(logic [7:0] c);
      return upper_ch(c) || lower_ch(c);
   endfunction

   function automatic logic [7:0] fold_up(logic [7:0] c);
      return lower_ch(c) ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] fold_down(logic [7:0] c);
      return upper_ch(c) ? c + 8'd32 : c;
   endfunction

   task automatic clear_text();
      pend_char  = 8'd0;
      pend_valid = 1'b0;
      word_prev  = 8'd0;
      in_word    = 1'b0;
      word_seen  = 1'b0;
      cap_next   = 1'b1;
   endtask

   task automatic put_byte(input logic [7:0] b);
      step_bytes_q.insert(step_bytes_q.size(), b);
   endtask

   // one byte through the word trackers, output bytes onto step_bytes_q
   task automatic convert_byte(input logic [7:0] ch, input logic nx_ok, input logic [7:0] nx);
      logic       fresh;
      logic       had_word;
      logic       alnum;
      logic       brk;
      logic [7:0] p;
      fresh    = cap_next;
      had_word = word_seen;
      alnum    = alpha_ch(ch) || digit_ch(ch);
      p        = word_prev;
      brk      = 1'b0;
      cap_next = !alpha_ch(ch);
      if (alnum) begin
         if (in_word) begin
            brk = (lower_ch(p) && upper_ch(ch)) || (alpha_ch(p) && digit_ch(ch)) ||
                  (digit_ch(p) && alpha_ch(ch)) ||
                  (upper_ch(p) && upper_ch(ch) && nx_ok && lower_ch(nx));
         end else begin
            brk = 1'b1;
         end
         in_word   = 1'b1;
         word_prev = ch;
         if (brk) begin
            word_seen = 1'b1;
         end
      end else begin
         in_word   = 1'b0;
         word_prev = 8'd0;
      end
      case (cur_mode)
         MODE_UPPER: put_byte(fold_up(ch));
         MODE_LOWER: put_byte(fold_down(ch));
         MODE_TITLE: begin
            if (alpha_ch(ch)) begin
               put_byte(fresh ? fold_up(ch) : fold_down(ch));
            end else begin
               put_byte(ch);
            end
         end
         MODE_SNAKE: begin
            if (alnum) begin
               if (brk && had_word) begin
                  put_byte(UNDERSCORE);
               end
               put_byte(fold_down(ch));
            end
         end
         MODE_CAMEL: begin
            if (alnum) begin
               put_byte((brk && had_word) ? fold_up(ch) : fold_down(ch));
            end
         end
         default: put_byte(ch);
      endcase
   endtask

   task automatic predict_conversion(input icc_req_type rq);
      icc_rsp_type r;
      int          n;
      int          i;
      step_bytes_q.delete();
      if (pend_valid) begin
         convert_byte(pend_char, 1'b1, rq.char_in);
      end
      if (rq.last_in) begin
         convert_byte(rq.char_in, 1'b0, 8'd0);
      end else begin
         pend_char  = rq.char_in;
         pend_valid = 1'b1;
      end
      n = step_bytes_q.size();
      for (i = 0; i < n; i++) begin
         r.byte_out   = step_bytes_q[i];
         r.byte_valid = 1'b1;
         r.run_last   = (i == n - 1);
         r.stream_end = rq.last_in && (i == n - 1);
         pending_rsp_q.insert(pending_rsp_q.size(), r);
      end
      if (rq.last_in) begin
         // the last request released no byte: a bare end marker instead
         if (n == 0) begin
            r            = '0;
            r.run_last   = 1'b1;
            r.stream_end = 1'b1;
            pending_rsp_q.insert(pending_rsp_q.size(), r);
         end
         clear_text();
      end
   endtask

   // called at a rising edge; returns at the edge that accepts the request
   task automatic send_request(input logic [7:0] ch, input logic fin);
      icc_req_type rq;
      rq.char_in = ch;
      rq.last_in = fin;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      predict_conversion(rq);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_request(s[i], i == s.len() - 1);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) begin
         @(posedge clock);
      end
      // a held first byte gives no response, so allow the pipe to settle
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [2:0] m);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_mode = m;
   endtask

   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      int         s;
      s = $urandom_range(99);
      if (s < 30) begin
         c = 8'h41 + 8'($urandom_range(25));
      end else if (s < 65) begin
         c = 8'h61 + 8'($urandom_range(25));
      end else if (s < 78) begin
         c = 8'h30 + 8'($urandom_range(9));
      end else if (s < 92) begin
         case ($urandom_range(3))
            0:       c = UNDERSCORE;
            1:       c = 8'h2D;
            2:       c = 8'h20;
            default: c = 8'h2E;
         endcase
      end else begin
         c = 8'($urandom_range(255));
      end
      return c;
   endfunction

   task automatic test_word_splitting();
      write_mode(MODE_SNAKE);
      send_text("XMLPa1 b");
      write_mode(MODE_CAMEL);
      send_text("aB-c");
   endtask

   task automatic test_plain_cases();
      write_mode(MODE_TITLE);
      send_request("h", 1'b0);
      send_request(8'hFF, 1'b0);
      send_request("i", 1'b1);
      write_mode(MODE_UPPER);
      send_request(8'h00, 1'b0);
      send_request("z", 1'b1);
      write_mode(MODE_LOWER);
      send_text("Q");
   endtask

   task automatic test_end_marker();
      write_mode(MODE_SNAKE);
      send_text("!");
      send_text("-.");
   endtask

   // held byte converted under the mode written after it arrived
   task automatic test_mode_switch();
      write_mode(MODE_PASS_TOP);
      send_request("A", 1'b0);
      write_mode(MODE_LOWER);
      send_request(8'h80, 1'b0);
      send_request("c", 1'b1);
   endtask

   task automatic test_backpressure();
      write_mode(MODE_SNAKE);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_left = HOLD_OFF_CYCLES;
      send_text("aB1cD2eF3gH4iJ5kL6mN7oP8");
   endtask

   task automatic test_random_texts(input int s_idle, input int r_idle, input int n_items);
      int         done;
      int         len;
      int         i;
      logic       noise;
      logic [7:0] ch;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      done = 0;
      while (done < n_items) begin
         if ($urandom_range(1) == 0) begin
            case ($urandom_range(9))
               0, 1, 2: write_mode(MODE_SNAKE);
               3, 4, 5: write_mode(MODE_CAMEL);
               default: write_mode(3'($urandom_range(7)));
            endcase
         end
         len   = ($urandom_range(9) == 0) ? $urandom_range(24, 1) : $urandom_range(10, 1);
         noise = ($urandom_range(9) == 0);
         for (i = 0; i < len; i++) begin
            ch = noise ? 8'($urandom_range(255)) : pick_char();
            send_request(ch, i == len - 1);
         end
         done += len;
      end
   endtask

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want_rsp = pending_rsp_q.pop_front();
            check_field("byte_out", want_rsp.byte_out, rsp_data.byte_out);
            check_field("byte_valid", {7'd0, want_rsp.byte_valid},
                        {7'd0, rsp_data.byte_valid});
            check_field("run_last", {7'd0, want_rsp.run_last}, {7'd0, rsp_data.run_last});
            check_field("stream_end", {7'd0, want_rsp.stream_end},
                        {7'd0, rsp_data.stream_end});
         end
      end
   end

   initial begin
      cur_mode = MODE_UPPER;
      clear_text();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_word_splitting();
      test_plain_cases();
      test_end_marker();
      test_mode_switch();
      test_random_texts(7, 55, 35);
      test_random_texts(55, 7, 35);
      test_backpressure();
      test_random_texts(0, 0, 35);
      wait_drained();
      if (mismatch_count == 0) begin
         $display("identifier_case_converter_unit test passed");
      end else begin
         $display("identifier_case_converter_unit test failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("identifier_case_converter_unit test failed");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/icc_pkg.sv
rtl/core/icc_front.sv
rtl/core/icc_queue.sv
rtl/core/icc_back.sv
rtl/core/identifier_case_converter_unit.sv
bench/tb_identifier_case_converter_unit.sv
